// File: sv/eci_pkg.sv
package eci_pkg;

   localparam int CoordW = 16;
   localparam int ProgW  = 16;

   // long-division unit: one quotient bit per stage
   localparam int DivSteps = 18;
   localparam int DivNumW  = 50;
   localparam int DivDenW  = 35;
   localparam int DivCmpW  = DivDenW + DivSteps;
   localparam int SideW    = 128;

   // lane datapath widths
   localparam int CoefW = 22;
   localparam int AW    = CoordW + 1;
   localparam int ProdW = AW + CoefW;
   localparam int SumW  = 20;

   localparam int QuadScale   = 1000;
   localparam int QuadScaleSq = 1000000;
   localparam int QuadTwice   = 2000;
   localparam int QuarterTurn = 16384;
   localparam int HalfTurn    = 32768;
   localparam int SineOne     = 65535;
   localparam int FullScaleRst = 1000;
   localparam int FullScaleMin = 2;

   // 5 * 2^30, base of the rational sine approximation denominator
   localparam logic [33:0] BhDen = 34'd5368709120;

   typedef enum logic [2:0] {
      CurveLinear    = 3'd0,
      CurveQuadIn    = 3'd1,
      CurveQuadOut   = 3'd2,
      CurveQuadInOut = 3'd3,
      CurveSineIn    = 3'd4,
      CurveSineOut   = 3'd5,
      CurveSineInOut = 3'd6
   } eci_curve_type;

   typedef enum logic [1:0] {
      CsrCurveMode = 2'd0,
      CsrFullScale = 2'd1
   } eci_csr_type;

   typedef struct packed {
      logic neg_a;
      logic half_a;
      logic half_p;
      logic use_end;
      logic hit;
   } eci_lane_ctl_type;

   typedef struct packed {
      logic                     sign;
      logic signed [CoordW:0]   addend;
      logic                     hit;
   } eci_lane_side_type;

   localparam int LaneSideW = $bits(eci_lane_side_type);

   typedef struct packed {
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic [ProgW-1:0]         p;
      logic                     hit;
      logic                     hi;
      logic signed [CoefW-1:0]  bq;
      logic                     neg;
      logic [14:0]              u;
   } eci_item_type;

   localparam int ItemW = $bits(eci_item_type);

endpackage

// File: sv/eci_div.sv
module eci_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [eci_pkg::DivNumW-1:0] in_num,
   input  logic [eci_pkg::DivDenW-1:0] in_den,
   input  logic [eci_pkg::SideW-1:0]   in_side,
   output logic                        out_valid,
   output logic [eci_pkg::DivSteps-1:0] out_quo,
   output logic [eci_pkg::SideW-1:0]   out_side
);

   logic [eci_pkg::DivNumW-1:0]  rem_ff   [eci_pkg::DivSteps];
   logic [eci_pkg::DivNumW-1:0]  rem_in   [eci_pkg::DivSteps];
   logic [eci_pkg::DivNumW-1:0]  num_src  [eci_pkg::DivSteps];
   logic [eci_pkg::DivDenW-1:0]  den_ff   [eci_pkg::DivSteps];
   logic [eci_pkg::DivDenW-1:0]  den_src  [eci_pkg::DivSteps];
   logic [eci_pkg::DivSteps-1:0] quo_ff   [eci_pkg::DivSteps];
   logic [eci_pkg::DivSteps-1:0] quo_in   [eci_pkg::DivSteps];
   logic [eci_pkg::DivSteps-1:0] quo_src  [eci_pkg::DivSteps];
   logic [eci_pkg::SideW-1:0]    side_ff  [eci_pkg::DivSteps];
   logic [eci_pkg::DivCmpW-1:0]  shifted  [eci_pkg::DivSteps];
   logic [eci_pkg::DivCmpW-1:0]  diff     [eci_pkg::DivSteps];
   logic [eci_pkg::DivSteps-1:0] take;
   logic [eci_pkg::DivSteps-1:0] valid_ff;

   always_comb begin
      num_src[0] = in_num;
      den_src[0] = in_den;
      quo_src[0] = '0;
      for (int k = 1; k < eci_pkg::DivSteps; k++) begin
         num_src[k] = rem_ff[k-1];
         den_src[k] = den_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      // stage k settles quotient bit DivSteps-1-k
      for (int k = 0; k < eci_pkg::DivSteps; k++) begin
         shifted[k] = eci_pkg::DivCmpW'(den_src[k]) << (eci_pkg::DivSteps - 1 - k);
         diff[k]    = eci_pkg::DivCmpW'(num_src[k]) - shifted[k];
         take[k]    = eci_pkg::DivCmpW'(num_src[k]) >= shifted[k];
         rem_in[k]  = take[k] ? diff[k][eci_pkg::DivNumW-1:0] : num_src[k];
         quo_in[k]  = quo_src[k];
         quo_in[k][eci_pkg::DivSteps-1-k] = take[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[eci_pkg::DivSteps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_den;
         for (int k = 1; k < eci_pkg::DivSteps; k++) begin
            side_ff[k] <= side_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
         end
         for (int k = 0; k < eci_pkg::DivSteps; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = valid_ff[eci_pkg::DivSteps-1];
   assign out_quo   = quo_ff[eci_pkg::DivSteps-1];
   assign out_side  = side_ff[eci_pkg::DivSteps-1];

endmodule

// File: sv/eci_lane.sv
module eci_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [eci_pkg::CoordW-1:0] in_start,
   input  logic signed [eci_pkg::CoordW-1:0] in_end,
   input  logic signed [eci_pkg::CoefW-1:0]  in_coef,
   input  eci_pkg::eci_lane_ctl_type       in_ctl,
   input  logic [eci_pkg::DivDenW-1:0]     in_den,
   output logic                            out_valid,
   output logic signed [eci_pkg::SumW-1:0] out_sum,
   output logic                            out_hit
);

   logic signed [eci_pkg::AW-1:0]    d;
   logic signed [eci_pkg::AW-1:0]    d_adj;
   logic signed [eci_pkg::AW-1:0]    d_half;
   logic signed [eci_pkg::AW-1:0]    a_mag;
   logic signed [eci_pkg::AW-1:0]    a_in;
   logic signed [eci_pkg::AW-1:0]    addend_in;

   logic signed [eci_pkg::AW-1:0]    a_ff;
   logic signed [eci_pkg::CoefW-1:0] b_ff;
   logic signed [eci_pkg::AW-1:0]    add0_ff;
   logic                             halfp0_ff;
   logic                             hit0_ff;
   logic [eci_pkg::DivDenW-1:0]      den0_ff;
   logic                             v0_ff;

   logic signed [eci_pkg::ProdW-1:0] prod_in;
   logic signed [eci_pkg::ProdW-1:0] prod_ff;
   logic signed [eci_pkg::AW-1:0]    add1_ff;
   logic                             halfp1_ff;
   logic                             hit1_ff;
   logic [eci_pkg::DivDenW-1:0]      den1_ff;
   logic                             v1_ff;

   logic [eci_pkg::ProdW-1:0]        mag;
   logic [eci_pkg::ProdW-1:0]        mag_sel;
   eci_pkg::eci_lane_side_type       side_in;
   eci_pkg::eci_lane_side_type       side_out;
   logic [eci_pkg::SideW-1:0]        div_side;
   logic                             div_valid;
   logic [eci_pkg::DivSteps-1:0]     div_quo;

   logic signed [eci_pkg::SumW-1:0]  q_pos;
   logic signed [eci_pkg::SumW-1:0]  sum_in;
   logic signed [eci_pkg::SumW-1:0]  sum_ff;
   logic                             hit_ff;
   logic                             v3_ff;

   always_comb begin
      d      = {in_end[eci_pkg::CoordW-1], in_end} - {in_start[eci_pkg::CoordW-1], in_start};
      // halve toward zero
      d_adj  = d + {{(eci_pkg::AW-1){1'b0}}, d[eci_pkg::AW-1]};
      d_half = d_adj >>> 1;
      a_mag  = in_ctl.half_a ? d_half : d;
      a_in   = in_ctl.neg_a ? -a_mag : a_mag;
      addend_in = in_ctl.use_end ? {in_end[eci_pkg::CoordW-1], in_end}
                                 : {in_start[eci_pkg::CoordW-1], in_start};
   end

   assign prod_in = a_ff * b_ff;

   always_comb begin
      mag     = prod_ff[eci_pkg::ProdW-1] ? eci_pkg::ProdW'(-prod_ff) : eci_pkg::ProdW'(prod_ff);
      mag_sel = halfp1_ff ? (mag >> 1) : mag;
      side_in.sign   = prod_ff[eci_pkg::ProdW-1];
      side_in.addend = add1_ff;
      side_in.hit    = hit1_ff;
   end

   eci_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1_ff),
      .in_num    (eci_pkg::DivNumW'(mag_sel)),
      .in_den    (den1_ff),
      .in_side   (eci_pkg::SideW'(side_in)),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   always_comb begin
      side_out = eci_pkg::eci_lane_side_type'(div_side[eci_pkg::LaneSideW-1:0]);
      q_pos    = eci_pkg::SumW'(div_quo);
      sum_in   = (side_out.sign ? -q_pos : q_pos) + eci_pkg::SumW'(side_out.addend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v3_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= a_in;
         b_ff      <= in_coef;
         add0_ff   <= addend_in;
         halfp0_ff <= in_ctl.half_p;
         hit0_ff   <= in_ctl.hit;
         den0_ff   <= in_den;
         prod_ff   <= prod_in;
         add1_ff   <= add0_ff;
         halfp1_ff <= halfp0_ff;
         hit1_ff   <= hit0_ff;
         den1_ff   <= den0_ff;
         sum_ff    <= sum_in;
         hit_ff    <= side_out.hit;
      end
   end

   assign out_valid = v3_ff;
   assign out_sum   = sum_ff;
   assign out_hit   = hit_ff;

endmodule

// File: sv/easing_curve_interpolator_unit.sv
// Eased 2-D point interpolator. Each request word carries a start point, an
// end point and a progress value; the response word carries the eased point
// and a clamped flag, set when progress ran past full_scale or a coordinate
// saturated to 16 bits. The curve (linear, quadratic in/out/in-out, sine
// in/out/in-out) and full_scale come from two CSRs that must only be written
// while no word is in flight. The block takes one word per cycle and returns
// each result through three 18-stage long-division units in series: the
// shared progress divider, the shared sine evaluator and the per-coordinate
// divider in each lane. The whole pipe advances together and holds while a
// result waits on rsp_ready.
module easing_curve_interpolator_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [eci_pkg::CoordW-1:0] req_start_x,
   input  logic signed [eci_pkg::CoordW-1:0] req_start_y,
   input  logic signed [eci_pkg::CoordW-1:0] req_end_x,
   input  logic signed [eci_pkg::CoordW-1:0] req_end_y,
   input  logic [eci_pkg::ProgW-1:0]         req_progress,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [eci_pkg::CoordW-1:0] rsp_out_x,
   output logic signed [eci_pkg::CoordW-1:0] rsp_out_y,
   output logic                              rsp_clamped,

   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [15:0]                       csr_wdata
);

   // CSRs
   logic [2:0]                   mode_ff;
   logic [eci_pkg::ProgW-1:0]    full_ff;
   logic [eci_pkg::ProgW-1:0]    f_eff;
   logic                         is_quad;
   logic                         is_sine;

   logic                         adv;

   // stage 0: clamp progress
   eci_pkg::eci_item_type        item0_in;
   eci_pkg::eci_item_type        item0_ff;
   logic                         v0_ff;
   logic                         over;
   logic [25:0]                  p1000;
   logic [eci_pkg::DivNumW-1:0]  num1;
   logic [eci_pkg::DivDenW-1:0]  den1;

   // progress divider
   logic                         d1_valid;
   logic [eci_pkg::DivSteps-1:0] q1;
   logic [eci_pkg::SideW-1:0]    side1;
   eci_pkg::eci_item_type        it1;

   // stage 1: quadratic term and sine angle
   eci_pkg::eci_item_type        item1_in;
   eci_pkg::eci_item_type        item1_ff;
   logic                         v1_ff;
   logic [11:0]                  t3;
   logic [11:0]                  t;
   logic                         hi;
   logic signed [12:0]           t_s;
   logic signed [12:0]           fac;
   logic signed [25:0]           bq_raw;
   logic [14:0]                  a4;
   logic [15:0]                  a6;

   // stage 2: rational sine numerator term
   logic [28:0]                  q_in;
   logic [28:0]                  q_ff;
   eci_pkg::eci_item_type        item2_ff;
   logic                         v2_ff;

   // sine divider
   logic [33:0]                  den3;
   logic [eci_pkg::DivNumW-1:0]  qq;
   logic [eci_pkg::DivNumW-1:0]  num65;
   logic [eci_pkg::DivNumW-1:0]  num2;
   logic                         d2_valid;
   logic [eci_pkg::DivSteps-1:0] q2;
   logic [eci_pkg::SideW-1:0]    side2;
   eci_pkg::eci_item_type        it2;

   // stage 4: lane coefficients
   logic signed [16:0]           s_val;
   logic signed [16:0]           c_val;
   logic signed [17:0]           c_m1;
   logic signed [eci_pkg::CoefW-1:0] b4_in;
   logic signed [eci_pkg::CoefW-1:0] b4_ff;
   eci_pkg::eci_lane_ctl_type    ctl4_in;
   eci_pkg::eci_lane_ctl_type    ctl4_ff;
   logic [eci_pkg::DivDenW-1:0]  den4_in;
   logic [eci_pkg::DivDenW-1:0]  den4_ff;
   eci_pkg::eci_item_type        item4_ff;
   logic                         v4_ff;

   // lanes and merge
   logic [1:0]                       lane_valid;
   logic [1:0]                       lane_hit;
   logic signed [eci_pkg::SumW-1:0]  sum_x;
   logic signed [eci_pkg::SumW-1:0]  sum_y;
   logic signed [eci_pkg::CoordW-1:0] sat_x;
   logic signed [eci_pkg::CoordW-1:0] sat_y;
   logic                             hit_x;
   logic                             hit_y;

   logic                             rsp_valid_ff;
   logic signed [eci_pkg::CoordW-1:0] rsp_x_ff;
   logic signed [eci_pkg::CoordW-1:0] rsp_y_ff;
   logic                             rsp_clamped_ff;

   // ---------------------------------------------------------------- CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= eci_pkg::CurveLinear;
         full_ff <= eci_pkg::ProgW'(eci_pkg::FullScaleRst);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            eci_pkg::CsrCurveMode: mode_ff <= csr_wdata[2:0];
            eci_pkg::CsrFullScale: full_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // full_scale of 0 or 1 acts as 2
   assign f_eff = (full_ff < eci_pkg::ProgW'(eci_pkg::FullScaleMin))
                  ? eci_pkg::ProgW'(eci_pkg::FullScaleMin) : full_ff;

   assign is_quad = (mode_ff == eci_pkg::CurveQuadIn) || (mode_ff == eci_pkg::CurveQuadOut) ||
                    (mode_ff == eci_pkg::CurveQuadInOut);
   assign is_sine = (mode_ff == eci_pkg::CurveSineIn) || (mode_ff == eci_pkg::CurveSineOut) ||
                    (mode_ff == eci_pkg::CurveSineInOut);

   // Advance the whole pipe whenever the response register is free or
   // being drained; hold everything otherwise.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ------------------------------------------------------------- stage 0
   always_comb begin
      over          = req_progress > f_eff;
      item0_in      = '0;
      item0_in.sx   = req_start_x;
      item0_in.sy   = req_start_y;
      item0_in.ex   = req_end_x;
      item0_in.ey   = req_end_y;
      item0_in.p    = over ? f_eff : req_progress;
      item0_in.hit  = over;
   end

   // quadratic curves divide p*1000, all other curves divide p*65536;
   // in-out quadratic divides by half the full scale
   always_comb begin
      p1000 = 26'(item0_ff.p) * 26'(eci_pkg::QuadScale);
      num1  = is_quad ? eci_pkg::DivNumW'(p1000) : eci_pkg::DivNumW'({item0_ff.p, 16'b0});
      den1  = (mode_ff == eci_pkg::CurveQuadInOut) ? eci_pkg::DivDenW'(f_eff >> 1)
                                                   : eci_pkg::DivDenW'(f_eff);
   end

   eci_div u_div_prog (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v0_ff),
      .in_num    (num1),
      .in_den    (den1),
      .in_side   (eci_pkg::SideW'(item0_ff)),
      .out_valid (d1_valid),
      .out_quo   (q1),
      .out_side  (side1)
   );

   // ------------------------------------------------------------- stage 1
   always_comb begin
      it1    = eci_pkg::eci_item_type'(side1[eci_pkg::ItemW-1:0]);
      t3     = q1[11:0];
      // second half of the in-out quadratic
      hi     = (mode_ff == eci_pkg::CurveQuadInOut) &&
               (q1 >= eci_pkg::DivSteps'(eci_pkg::QuadScale));
      t      = hi ? (t3 - 12'(eci_pkg::QuadScale)) : t3;
      t_s    = {1'b0, t};
      if ((mode_ff == eci_pkg::CurveQuadIn) ||
          ((mode_ff == eci_pkg::CurveQuadInOut) && !hi)) begin
         fac = t_s;
      end else begin
         fac = t_s - 13'(eci_pkg::QuadTwice);
      end
      bq_raw = t_s * fac;
      a4     = q1[16:2];
      a6     = q1[16:1];

      item1_in     = it1;
      item1_in.hi  = hi;
      item1_in.bq  = hi ? eci_pkg::CoefW'(bq_raw - 26'(eci_pkg::QuadScaleSq))
                        : eci_pkg::CoefW'(bq_raw);
      item1_in.u   = '0;
      item1_in.neg = 1'b0;
      // fold the angle to a quarter wave; cos(a) = sin(a + quarter turn)
      case (mode_ff)
         eci_pkg::CurveSineIn: begin
            item1_in.u = 15'(eci_pkg::QuarterTurn) - a4;
         end
         eci_pkg::CurveSineOut: begin
            item1_in.u = a4;
         end
         eci_pkg::CurveSineInOut: begin
            if (a6 <= 16'(eci_pkg::QuarterTurn)) begin
               item1_in.u = 15'(16'(eci_pkg::QuarterTurn) - a6);
            end else begin
               item1_in.u   = 15'(a6 - 16'(eci_pkg::QuarterTurn));
               item1_in.neg = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- stage 2
   assign q_in = 29'(item1_ff.u) * 29'(16'(eci_pkg::HalfTurn) - 16'(item1_ff.u));

   // sine(u) = round(65535*16q / (5*2^30 - 4q)), q = u*(32768-u)
   always_comb begin
      den3  = eci_pkg::BhDen - (34'(q_ff) << 2);
      qq    = eci_pkg::DivNumW'(q_ff);
      num65 = (qq << 16) - qq;
      num2  = (num65 << 5) + eci_pkg::DivNumW'(den3);
   end

   eci_div u_div_sine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_num    (num2),
      .in_den    (eci_pkg::DivDenW'({den3, 1'b0})),
      .in_side   (eci_pkg::SideW'(item2_ff)),
      .out_valid (d2_valid),
      .out_quo   (q2),
      .out_side  (side2)
   );

   // ------------------------------------------------------------- stage 4
   always_comb begin
      it2   = eci_pkg::eci_item_type'(side2[eci_pkg::ItemW-1:0]);
      s_val = {1'b0, q2[15:0]};
      c_val = it2.neg ? -s_val : s_val;
      c_m1  = 18'(c_val) - 18'(eci_pkg::SineOne);

      ctl4_in.hit     = it2.hit;
      ctl4_in.neg_a   = (mode_ff == eci_pkg::CurveQuadOut) ||
                        (mode_ff == eci_pkg::CurveSineIn) ||
                        (mode_ff == eci_pkg::CurveSineInOut) ||
                        ((mode_ff == eci_pkg::CurveQuadInOut) && it2.hi);
      ctl4_in.half_a  = mode_ff == eci_pkg::CurveQuadInOut;
      ctl4_in.half_p  = mode_ff == eci_pkg::CurveSineInOut;
      ctl4_in.use_end = mode_ff == eci_pkg::CurveSineIn;

      if (is_quad) begin
         den4_in = eci_pkg::DivDenW'(eci_pkg::QuadScaleSq);
      end else if (is_sine) begin
         den4_in = eci_pkg::DivDenW'(eci_pkg::SineOne);
      end else begin
         den4_in = eci_pkg::DivDenW'(f_eff);
      end

      case (mode_ff) inside
         eci_pkg::CurveQuadIn,
         eci_pkg::CurveQuadOut,
         eci_pkg::CurveQuadInOut: b4_in = it2.bq;
         eci_pkg::CurveSineIn,
         eci_pkg::CurveSineOut:   b4_in = eci_pkg::CoefW'(c_val);
         eci_pkg::CurveSineInOut: b4_in = eci_pkg::CoefW'(c_m1);
         default:                 b4_in = eci_pkg::CoefW'({1'b0, it2.p});
      endcase
   end

   // --------------------------------------------------- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= d1_valid;
         v2_ff <= v1_ff;
         v4_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item0_ff <= item0_in;
         item1_ff <= item1_in;
         item2_ff <= item1_ff;
         q_ff     <= q_in;
         item4_ff <= it2;
         b4_ff    <= b4_in;
         ctl4_ff  <= ctl4_in;
         den4_ff  <= den4_in;
      end
   end

   // ---------------------------------------------------------------- lanes
   eci_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_start  (item4_ff.sx),
      .in_end    (item4_ff.ex),
      .in_coef   (b4_ff),
      .in_ctl    (ctl4_ff),
      .in_den    (den4_ff),
      .out_valid (lane_valid[0]),
      .out_sum   (sum_x),
      .out_hit   (lane_hit[0])
   );

   eci_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_start  (item4_ff.sy),
      .in_end    (item4_ff.ey),
      .in_coef   (b4_ff),
      .in_ctl    (ctl4_ff),
      .in_den    (den4_ff),
      .out_valid (lane_valid[1]),
      .out_sum   (sum_y),
      .out_hit   (lane_hit[1])
   );

   // ---------------------------------------------------------------- merge
   // saturate each coordinate and fold overrun and saturation into one flag
   always_comb begin
      hit_x = 1'b1;
      hit_y = 1'b1;
      if (sum_x > eci_pkg::SumW'(32767)) begin
         sat_x = 16'sh7FFF;
      end else if (sum_x < -eci_pkg::SumW'(32768)) begin
         sat_x = -16'sh8000;
      end else begin
         sat_x = sum_x[eci_pkg::CoordW-1:0];
         hit_x = 1'b0;
      end
      if (sum_y > eci_pkg::SumW'(32767)) begin
         sat_y = 16'sh7FFF;
      end else if (sum_y < -eci_pkg::SumW'(32768)) begin
         sat_y = -16'sh8000;
      end else begin
         sat_y = sum_y[eci_pkg::CoordW-1:0];
         hit_y = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= lane_valid[0] & lane_valid[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff       <= sat_x;
         rsp_y_ff       <= sat_y;
         rsp_clamped_ff <= lane_hit[0] | lane_hit[1] | hit_x | hit_y;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = rsp_x_ff;
   assign rsp_out_y   = rsp_y_ff;
   assign rsp_clamped = rsp_clamped_ff;

endmodule

// File: test/easing_curve_interpolator_unit_tb.sv
`timescale 1ns / 1ps

module easing_curve_interpolator_unit_tb;

   localparam int TableDepth = 16385;
   localparam int WatchLimit = 5000;
   localparam int HoldOffLen = 400;
   localparam int DrainWait  = 120;
   localparam int FullTurn   = 65536;
   // indexes that decode to no register; writes to them must be ignored
   localparam logic [1:0] CsrSpareA = 2'd2;
   localparam logic [1:0] CsrSpareB = 2'd3;
   // curve code with no curve of its own
   localparam logic [2:0] CurveSpare = 3'd7;

   typedef struct packed {
      logic signed [eci_pkg::CoordW-1:0] x;
      logic signed [eci_pkg::CoordW-1:0] y;
      logic                              clamped;
   } eased_point_type;

   typedef struct {
      logic [2:0]                        mode;
      logic [15:0]                       fs;
      logic signed [eci_pkg::CoordW-1:0] sx, sy, ex, ey;
      logic [eci_pkg::ProgW-1:0]         p;
      logic                              known;
      eased_point_type                   want;
   } directed_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [eci_pkg::CoordW-1:0] req_start_x = '0;
   logic signed [eci_pkg::CoordW-1:0] req_start_y = '0;
   logic signed [eci_pkg::CoordW-1:0] req_end_x = '0;
   logic signed [eci_pkg::CoordW-1:0] req_end_y = '0;
   logic [eci_pkg::ProgW-1:0]         req_progress = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [eci_pkg::CoordW-1:0] rsp_out_x;
   logic signed [eci_pkg::CoordW-1:0] rsp_out_y;
   logic                              rsp_clamped;
   logic                              csr_wr_en = 1'b0;
   logic [1:0]                        csr_index = '0;
   logic [15:0]                       csr_wdata = '0;

   easing_curve_interpolator_unit u_top (.*);

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers and the quarter-wave sine ROM
   longint      sine_quarter[TableDepth];
   logic [2:0]  curve_q = eci_pkg::CurveLinear;
   logic [15:0] full_scale_q = 16'(eci_pkg::FullScaleRst);

   eased_point_type pending_points[$];
   int  mismatches = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_off_left = 0;
   bit  accepted_in, accepted_out;

   function automatic longint rational_sine(longint u);
      longint q, den, num;
      q = u * (eci_pkg::HalfTurn - u);
      den = 64'sd5368709120 - 4 * q;
      num = longint'(eci_pkg::SineOne) * 16 * q;
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic longint quarter_lookup(longint a);
      longint idx;
      idx = a * (TableDepth - 1) / eci_pkg::QuarterTurn;
      if (idx < 0) idx = 0;
      if (idx > TableDepth - 1) idx = TableDepth - 1;
      return sine_quarter[idx];
   endfunction

   function automatic longint sine_at(longint angle);
      longint a;
      a = angle & (FullTurn - 1);
      if (a <= eci_pkg::QuarterTurn) return quarter_lookup(a);
      if (a <= eci_pkg::HalfTurn) return quarter_lookup(eci_pkg::HalfTurn - a);
      if (a <= 3 * eci_pkg::QuarterTurn) return -quarter_lookup(a - eci_pkg::HalfTurn);
      return -quarter_lookup(FullTurn - a);
   endfunction

   // one coordinate along the selected curve, all in 64-bit with C truncation
   function automatic longint ease_coord(longint s, longint e, longint p, longint f,
                                         logic [2:0] mode);
      longint d, t;
      d = e - s;
      case (mode)
         eci_pkg::CurveQuadIn: begin
            t = p * eci_pkg::QuadScale / f;
            return d * t * t / eci_pkg::QuadScaleSq + s;
         end
         eci_pkg::CurveQuadOut: begin
            t = p * eci_pkg::QuadScale / f;
            return (-d) * t * (t - eci_pkg::QuadTwice) / eci_pkg::QuadScaleSq + s;
         end
         eci_pkg::CurveQuadInOut: begin
            t = p * eci_pkg::QuadScale / (f / 2);
            if (t < eci_pkg::QuadScale) return (d / 2) * t * t / eci_pkg::QuadScaleSq + s;
            t -= eci_pkg::QuadScale;
            return ((-d) / 2) * (t * (t - eci_pkg::QuadTwice) - eci_pkg::QuadScaleSq)
                   / eci_pkg::QuadScaleSq + s;
         end
         eci_pkg::CurveSineIn:
            return ((-d) * sine_at(FullTurn * p / f / 4 + eci_pkg::QuarterTurn))
                   / eci_pkg::SineOne + d + s;
         eci_pkg::CurveSineOut:
            return (d * sine_at(FullTurn * p / f / 4)) / eci_pkg::SineOne + s;
         eci_pkg::CurveSineInOut:
            return (((-d) * (sine_at(FullTurn * p / f / 2 + eci_pkg::QuarterTurn)
                             - eci_pkg::SineOne)) / 2) / eci_pkg::SineOne + s;
         default:
            return s + d * p / f;
      endcase
   endfunction

   function automatic logic signed [eci_pkg::CoordW-1:0] clip_coord(longint v, ref logic hit);
      if (v > 32767) begin
         hit = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         hit = 1'b1;
         return 16'sh8000;
      end
      return v[eci_pkg::CoordW-1:0];
   endfunction

   function automatic eased_point_type predict_point(
         logic signed [eci_pkg::CoordW-1:0] sx, sy, ex, ey,
         logic [eci_pkg::ProgW-1:0] prog);
      eased_point_type r;
      longint f, p;
      logic hit;
      f = (full_scale_q < eci_pkg::FullScaleMin) ? eci_pkg::FullScaleMin : full_scale_q;
      p = prog;
      hit = 1'b0;
      if (p > f) begin
         p = f;
         hit = 1'b1;
      end
      r.x = clip_coord(ease_coord(sx, ex, p, f, curve_q), hit);
      r.y = clip_coord(ease_coord(sy, ey, p, f, curve_q), hit);
      r.clamped = hit;
      return r;
   endfunction

   // compare each returned word with the oldest prediction; watchdog on no traffic
   always @(posedge clock) begin
      eased_point_type w;
      accepted_in = req_valid && req_ready;
      accepted_out = rsp_valid && rsp_ready;
      if (!reset && accepted_out) begin
         words_checked++;
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: x=%0d y=%0d clamped=%0b",
                        rsp_out_x, rsp_out_y, rsp_clamped);
         end else begin
            w = pending_points.pop_front();
            if (w.x !== rsp_out_x || w.y !== rsp_out_y || w.clamped !== rsp_clamped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%0d y=%0d clamped=%0b, got x=%0d y=%0d clamped=%0b",
                           w.x, w.y, w.clamped, rsp_out_x, rsp_out_y, rsp_clamped);
            end
         end
      end
      if (reset || accepted_in || accepted_out || csr_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
         $display("timeout: no traffic for %0d cycles", WatchLimit);
         $display("easing_curve_interpolator_unit_tb: FAIL");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(logic signed [eci_pkg::CoordW-1:0] sx, sy, ex, ey,
                            logic [eci_pkg::ProgW-1:0] p);
      // drop valid for a while when the sender idles, else keep it high
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_start_x = sx;
      req_start_y = sy;
      req_end_x = ex;
      req_end_y = ey;
      req_progress = p;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_points.push_back(predict_point(sx, sy, ex, ey, p));
      words_sent++;
      @(negedge clock);
   endtask

   // hold until every predicted word has come back
   task automatic drain();
      req_valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == eci_pkg::CsrCurveMode) curve_q = data[2:0];
      else if (idx == eci_pkg::CsrFullScale) full_scale_q = data;
   endtask

   task automatic set_curve(logic [2:0] mode, logic [15:0] fs);
      if (mode == curve_q && fs == full_scale_q) return;
      drain();
      write_csr(eci_pkg::CsrCurveMode, {13'd0, mode});
      write_csr(eci_pkg::CsrFullScale, fs);
   endtask

   function automatic logic signed [eci_pkg::CoordW-1:0] pick_coord();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic directed_row_type row(logic [2:0] m, int fs,
                                            int sx, int sy, int ex, int ey, int p,
                                            bit known = 0, int wx = 0, int wy = 0,
                                            bit wc = 0);
      directed_row_type r;
      r.mode = m; r.fs = 16'(fs);
      r.sx = 16'(sx); r.sy = 16'(sy); r.ex = 16'(ex); r.ey = 16'(ey); r.p = 16'(p);
      r.known = known;
      r.want.x = 16'(wx); r.want.y = 16'(wy); r.want.clamped = wc;
      return r;
   endfunction

   directed_row_type directed[$];

   initial begin
      eased_point_type got;
      logic [15:0] fs_pick[8];
      logic [15:0] fs;
      logic [2:0] mode;
      longint lim;
      int n;

      for (int k = 0; k < TableDepth; k++)
         sine_quarter[k] = rational_sine(longint'(k) * eci_pkg::QuarterTurn / (TableDepth - 1));

      // values after reset, then the extremes; known rows carry their result
      directed.push_back(row(eci_pkg::CurveLinear, 1000, 0, 0, 1000, -1000, 500,
                             1, 500, -500, 0));
      directed.push_back(row(eci_pkg::CurveLinear, 1000, 123, -45, 999, 77, 0,
                             1, 123, -45, 0));
      directed.push_back(row(eci_pkg::CurveLinear, 1000, -32768, 32767, 32767, -32768, 1000,
                             1, 32767, -32768, 0));
      // progress past full scale pins to the end point and flags it
      directed.push_back(row(eci_pkg::CurveLinear, 1000, -32768, 32767, 32767, -32768, 65535,
                             1, 32767, -32768, 1));
      // full scale of zero or one behaves as two
      directed.push_back(row(eci_pkg::CurveLinear, 0, 0, 0, 100, -100, 1, 1, 50, -50, 0));
      directed.push_back(row(eci_pkg::CurveLinear, 0, 0, 0, 100, -100, 5, 1, 100, -100, 1));
      directed.push_back(row(eci_pkg::CurveLinear, 1, 0, 0, 100, -100, 2, 1, 100, -100, 0));
      // the spare curve code falls back to linear
      directed.push_back(row(CurveSpare, 1000, 0, 0, 400, 800, 250, 1, 100, 200, 0));
      directed.push_back(row(eci_pkg::CurveQuadIn, 1000, 10, 20, -30, 40, 1000,
                             1, -30, 40, 0));
      directed.push_back(row(eci_pkg::CurveQuadIn, 1000, -32768, 5, 32767, -7, 333));
      directed.push_back(row(eci_pkg::CurveQuadOut, 1000, 10, 20, -30, 40, 0, 1, 10, 20, 0));
      directed.push_back(row(eci_pkg::CurveQuadOut, 1000, 32767, -32768, -32768, 32767, 700));
      directed.push_back(row(eci_pkg::CurveQuadInOut, 1000, -1000, 3, 2001, -3, 400));
      directed.push_back(row(eci_pkg::CurveQuadInOut, 1000, -1000, 3, 2001, -3, 600));
      directed.push_back(row(eci_pkg::CurveQuadInOut, 5, -32768, 32767, 32767, -32768, 5));
      directed.push_back(row(eci_pkg::CurveSineIn, 1000, 7, -9, 500, 600, 0, 1, 7, -9, 0));
      directed.push_back(row(eci_pkg::CurveSineIn, 1000, -32768, 32767, 32767, -32768, 500));
      directed.push_back(row(eci_pkg::CurveSineOut, 1000, 7, -9, 500, 600, 1000,
                             1, 500, 600, 0));
      directed.push_back(row(eci_pkg::CurveSineOut, 1000, 7, -9, 500, 600, 300));
      directed.push_back(row(eci_pkg::CurveSineInOut, 1000, 7, -9, 500, 600, 1000,
                             1, 500, 600, 0));
      directed.push_back(row(eci_pkg::CurveSineInOut, 1000, 7, -9, 500, 600, 123));
      directed.push_back(row(eci_pkg::CurveSineInOut, 65535, -32768, 32767, 32767, -32768,
                             65535, 1, 32767, -32768, 0));
      directed.push_back(row(eci_pkg::CurveSineInOut, 65535, 1, 2, 3000, -3000, 40000));

      // hold reset, then release it before the first word
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed words: known rows also check the predictor itself
      foreach (directed[i]) begin
         set_curve(directed[i].mode, directed[i].fs);
         if (directed[i].known) begin
            got = predict_point(directed[i].sx, directed[i].sy, directed[i].ex,
                                directed[i].ey, directed[i].p);
            if (got != directed[i].want) begin
               mismatches++;
               $display("row %0d: predictor x=%0d y=%0d clamped=%0b, table x=%0d y=%0d",
                        i, got.x, got.y, got.clamped, directed[i].want.x, directed[i].want.y);
            end
         end
         send_word(directed[i].sx, directed[i].sy, directed[i].ex, directed[i].ey,
                   directed[i].p);
      end

      // unknown register indexes must leave both registers alone
      drain();
      write_csr(CsrSpareA, 16'($urandom));
      write_csr(CsrSpareB, 16'($urandom));

      fs_pick = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd1000, 16'd65535, 16'd0};
      for (int s = 0; s < 16; s++) begin
         mode = 3'(s % 8);
         fs = (s % 8 == 7) ? 16'($urandom_range(2, 65535)) : fs_pick[(s * 5) % 7];
         set_curve(mode, fs);
         case ((s / 2) % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         // fill the pipe against a stopped receiver once
         if (s == 5) hold_off_left = HoldOffLen;
         lim = (fs < eci_pkg::FullScaleMin) ? eci_pkg::FullScaleMin : fs;
         lim = lim + lim / 8;
         if (lim > 65535) lim = 65535;
         n = 100;
         for (int i = 0; i < n; i++) begin
            send_word(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      ($urandom_range(3) == 0)
                      ? eci_pkg::ProgW'($urandom)
                      : eci_pkg::ProgW'($urandom_range(0, int'(lim))));
         end
      end

      drain();
      repeat (DrainWait) @(negedge clock);

      $display("covered %0d words, %0d returned, over all curve codes and full scales",
               words_sent, words_checked);
      $display("from 0 to 65535, with sender gaps, receiver stalls and a long hold-off");
      if (mismatches == 0 && pending_points.size() == 0)
         $display("easing_curve_interpolator_unit_tb: PASS");
      else
         $display("easing_curve_interpolator_unit_tb: FAIL");
      $finish;
   end

endmodule
